// File: hdl/bfq_pkg.sv
// ----------------------------------------------------------------------------
// bfq_pkg
// Shared types and constants for the BF16 to FP8 scaled quantizer pipeline.
// ----------------------------------------------------------------------------
package bfq_pkg;

  localparam int QBITS = 27;

  localparam logic [1:0]  CFG_SCALE   = 2'd0;
  localparam logic [1:0]  CFG_FORMAT  = 2'd1;
  localparam logic        FMT_E4M3    = 1'b0;
  localparam logic        FMT_E5M2    = 1'b1;
  localparam logic [15:0] SCALE_RESET = 16'h3F80;
  localparam logic [14:0] LIM_E4M3    = 15'h43E0;
  localparam logic [14:0] LIM_E5M2    = 15'h4760;
  localparam logic [7:0]  NAN_BYTE    = 8'hFF;

  typedef enum logic [1:0] {
    CLS_NUM,
    CLS_ZERO,
    CLS_INF,
    CLS_NAN
  } cls_t;

  typedef struct packed {
    logic              sign;
    cls_t              cls;
    logic signed [10:0] p;
    logic [7:0]        ms;
    logic [8:0]        rem;
    logic [QBITS-1:0]  q;
  } div_t;

  typedef struct packed {
    logic        sign;
    logic        nan;
    logic [14:0] mag;
  } bfv_t;

endpackage

// File: hdl/bfq_unpack.sv
// ----------------------------------------------------------------------------
// bfq_unpack
// Classify operands, normalize significands, form the quotient exponent.
// ----------------------------------------------------------------------------
module bfq_unpack import bfq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        vin,
  input  logic [15:0] bf16_in,
  input  logic [15:0] scale_bits,
  output logic        vout,
  output div_t        dout
);

  function automatic logic [18:0] norm(input logic [15:0] b);
    logic [7:0]         mt;
    logic signed [10:0] ex;
    logic [2:0]         lz;
    lz = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (b[i]) lz = 3'(7 - i);
    end
    if (b[14:7] == 8'd0) begin
      mt = b[7:0] << lz;
      ex = -11'sd133 - $signed({8'd0, lz});
    end else begin
      mt = {1'b1, b[6:0]};
      ex = $signed({3'b0, b[14:7]}) - 11'sd134;
    end
    return {mt, ex};
  endfunction

  logic [18:0] nx, ns;
  logic        xz, xi, xn, sz, si, sn;
  div_t        d_next;

  always_comb begin
    nx = norm(bf16_in);
    ns = norm(scale_bits);
    xz = (bf16_in[14:0] == 15'd0);
    xi = (bf16_in[14:7] == 8'hFF) && (bf16_in[6:0] == 7'd0);
    xn = (bf16_in[14:7] == 8'hFF) && (bf16_in[6:0] != 7'd0);
    sz = (scale_bits[14:0] == 15'd0);
    si = (scale_bits[14:7] == 8'hFF) && (scale_bits[6:0] == 7'd0);
    sn = (scale_bits[14:7] == 8'hFF) && (scale_bits[6:0] != 7'd0);
    d_next.sign = bf16_in[15] ^ scale_bits[15];
    priority if (xn || sn || (xz && sz) || (xi && si)) begin
      d_next.cls = CLS_NAN;
    end else if (xi || sz) begin
      d_next.cls = CLS_INF;
    end else if (xz || si) begin
      d_next.cls = CLS_ZERO;
    end else begin
      d_next.cls = CLS_NUM;
    end
    d_next.p   = $signed(nx[10:0]) - $signed(ns[10:0]) - 11'sd26;
    d_next.ms  = ns[18:11];
    d_next.rem = {1'b0, nx[18:11]};
    d_next.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= d_next;
    end
  end

endmodule

// File: hdl/bfq_div_stage.sv
// ----------------------------------------------------------------------------
// bfq_div_stage
// STEPS restoring division steps on the significand quotient.
// ----------------------------------------------------------------------------
module bfq_div_stage import bfq_pkg::*; #(
  parameter int STEPS = 7
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  div_t din,
  output logic vout,
  output div_t dout
);

  div_t d_next;
  logic [8:0] r;
  logic [QBITS-1:0] q;

  always_comb begin
    r = din.rem;
    q = din.q;
    for (int i = 0; i < STEPS; i++) begin
      if (r >= {1'b0, din.ms}) begin
        r = r - {1'b0, din.ms};
        q = {q[QBITS-2:0], 1'b1};
      end else begin
        q = {q[QBITS-2:0], 1'b0};
      end
      r = {r[7:0], 1'b0};
    end
    d_next     = din;
    d_next.rem = r;
    d_next.q   = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= d_next;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (vout && dout.cls == CLS_NUM) |-> (dout.rem < {dout.ms, 1'b0}))
    else $error("partial remainder out of range");

endmodule

// File: hdl/bfq_round.sv
// ----------------------------------------------------------------------------
// bfq_round
// Round the quotient to FP32, then to BF16, and clamp to the format limit.
// ----------------------------------------------------------------------------
module bfq_round import bfq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic fmt,
  input  logic vin,
  input  div_t din,
  output logic vout,
  output bfv_t dout
);

  logic               n;
  logic signed [10:0] sh_norm, sh_sub, sh_s, be;
  logic [4:0]         sh;
  logic [31:0]        qe, t, mask;
  logic               half, low;
  logic [24:0]        rr;
  logic [7:0]         e8;
  logic [30:0]        w;
  logic [31:0]        rb;
  logic [14:0]        h, lim;
  bfv_t               d_next;

  always_comb begin
    n       = din.q[QBITS-1];
    sh_norm = n ? 11'sd3 : 11'sd2;
    sh_sub  = -11'sd149 - din.p;
    sh_s    = (sh_sub > sh_norm) ? sh_sub : sh_norm;
    sh      = (sh_s > 11'sd28) ? 5'd28 : sh_s[4:0];
    qe      = {{(32-QBITS){1'b0}}, din.q};
    t       = qe >> sh;
    half    = qe[sh - 5'd1];
    mask    = (32'd1 << (sh - 5'd1)) - 32'd1;
    low     = (|(qe & mask)) || (din.rem != 9'd0);
    rr      = t[24:0] + {24'd0, half && (low || t[0])};
    be      = din.p + $signed({10'd0, n}) + 11'sd152;
    e8      = (be < 11'sd1) ? 8'd0 : 8'(be - 11'sd1);
    if (be >= 11'sd255) begin
      w = 31'h7F800000;
    end else begin
      w = {e8, 23'd0} + {6'd0, rr};
    end
    unique case (din.cls)
      CLS_ZERO: w = '0;
      CLS_INF:  w = 31'h7F800000;
      default:  ;
    endcase
    rb  = {1'b0, w} + 32'h7FFF + {31'd0, w[16]};
    h   = rb[30:16];
    lim = (fmt == FMT_E5M2) ? LIM_E5M2 : LIM_E4M3;
    d_next.sign = din.sign;
    d_next.nan  = (din.cls == CLS_NAN);
    d_next.mag  = (h > lim) ? lim : h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= d_next;
    end
  end

  a_clamped: assert property (@(posedge clk) disable iff (rst)
    (vout && !dout.nan) |-> (dout.mag <= LIM_E5M2))
    else $error("clamped magnitude above limit");

endmodule

// File: hdl/bfq_encode.sv
// ----------------------------------------------------------------------------
// bfq_encode
// Encode a clamped BF16 value to an E4M3 or E5M2 byte, round nearest even.
// ----------------------------------------------------------------------------
module bfq_encode import bfq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       fmt,
  input  logic       vin,
  input  bfv_t       din,
  output logic       vout,
  output logic [7:0] dout
);

  function automatic logic [7:0] shr_rne(input logic [7:0] v, input int s);
    logic [8:0] t, r, hv;
    if (s <= 0) return v;
    if (s >= 10) return 8'd0;
    t  = {1'b0, v} >> s;
    r  = {1'b0, v} & 9'((1 << s) - 1);
    hv = 9'(1 << (s - 1));
    return 8'(t + {8'd0, (r > hv) || ((r == hv) && t[0])});
  endfunction

  int         e, te, bias, mbits;
  logic [7:0] v, sig, sub, res;

  always_comb begin
    e     = int'(din.mag[14:7]);
    bias  = (fmt == FMT_E5M2) ? 15 : 7;
    mbits = (fmt == FMT_E5M2) ? 2 : 3;
    te    = e - 127 + bias;
    v     = {1'b1, din.mag[6:0]};
    sig   = 8'd0;
    sub   = 8'd0;
    if (din.nan) begin
      res = NAN_BYTE;
    end else if (e == 0) begin
      res = {din.sign, 7'd0};
    end else if (te <= 0) begin
      sub = shr_rne(v, 135 - e - bias - mbits);
      res = {din.sign, sub[6:0]};
    end else begin
      sig = shr_rne(v, 7 - mbits);
      if (sig == 8'(1 << (mbits + 1))) begin
        te  = te + 1;
        sig = sig >> 1;
      end
      sig = sig - 8'(1 << mbits);
      res = {din.sign, 7'((te << mbits) | int'(sig))};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= res;
    end
  end

endmodule

// File: hdl/bf16_to_fp8_scaled_quantizer.sv
// ----------------------------------------------------------------------------
// bf16_to_fp8_scaled_quantizer
// Divide each BF16 element by a BF16 scale and encode it as FP8.
//
//   channel  signals                          direction
//   input    in_valid in_ready bf16_in        in
//   output   out_valid out_ready fp8_out      out
//   config   cfg_we cfg_index cfg_data        in
//
// One element per cycle, unless the output stalls, through seven register stages.
// Four pipelined restoring division stages set the depth.
// Synchronous reset clears valid bits and loads scale 1.0, format E4M3.
// A stall at the output holds every stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module bf16_to_fp8_scaled_quantizer import bfq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] bf16_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  fp8_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] scale_bits;
  logic        out_format;
  logic        en;
  logic [4:0]  v;
  div_t        d0, d1, d2, d3, d4;
  bfv_t        rnd_q;
  logic        rnd_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_bits <= SCALE_RESET;
      out_format <= FMT_E4M3;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SCALE)  scale_bits <= cfg_data;
      if (cfg_index == CFG_FORMAT) out_format <= cfg_data[0];
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  bfq_unpack u_unpack (
    .clk, .rst, .en, .vin(in_valid), .bf16_in, .scale_bits,
    .vout(v[0]), .dout(d0)
  );

  bfq_div_stage #(.STEPS(7)) u_div0 (
    .clk, .rst, .en, .vin(v[0]), .din(d0), .vout(v[1]), .dout(d1)
  );
  bfq_div_stage #(.STEPS(7)) u_div1 (
    .clk, .rst, .en, .vin(v[1]), .din(d1), .vout(v[2]), .dout(d2)
  );
  bfq_div_stage #(.STEPS(7)) u_div2 (
    .clk, .rst, .en, .vin(v[2]), .din(d2), .vout(v[3]), .dout(d3)
  );
  bfq_div_stage #(.STEPS(QBITS - 21)) u_div3 (
    .clk, .rst, .en, .vin(v[3]), .din(d3), .vout(v[4]), .dout(d4)
  );

  bfq_round u_round (
    .clk, .rst, .en, .fmt(out_format), .vin(v[4]), .din(d4),
    .vout(rnd_v), .dout(rnd_q)
  );

  bfq_encode u_encode (
    .clk, .rst, .en, .fmt(out_format), .vin(rnd_v), .din(rnd_q),
    .vout(out_valid), .dout(fp8_out)
  );

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> ($stable(rnd_q) && $stable(rnd_v) && $stable(v)))
    else $error("pipeline moved during stall");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BF16 to FP8 scaled quantizer testbench
// Streams BF16 elements through the quantizer under several scale and format
// settings and checks every FP8 byte against an integer model of the FP32
// divide, the BF16 rounding, the saturation and the FP8 encoding.
// ----------------------------------------------------------------------------
module testbench;
  import bfq_pkg::*;

  localparam int  LIMIT_CYCLES = 600000;
  localparam int  DRAIN_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] bf16_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  fp8_out;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SCALE;
  logic [15:0] cfg_data = '0;

  logic [15:0] cur_scale = SCALE_RESET;
  logic        cur_format = FMT_E4M3;
  logic [7:0]  fp8_expected[$];
  logic [15:0] fp8_source[$];
  int          errors = 0;
  int          sent = 0;
  int          checked = 0;
  int          cycles = 0;
  int          stall_left = 0;
  bit          no_gaps = 1'b0;

  bf16_to_fp8_scaled_quantizer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .bf16_in(bf16_in),
    .out_valid(out_valid), .out_ready(out_ready), .fp8_out(fp8_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("status: fail");
      $finish;
    end
  end

  // FP32 quotient of two BF16 patterns, round to nearest even
  function automatic logic [31:0] fp32_quotient(input logic [15:0] a, input logic [15:0] d);
    logic        sg, st, g, low;
    int          ea, ed, ex, es, p, e, sh, base;
    logic [63:0] xs, ss, q, r, kept, bits;
    bit          a_nan, d_nan, a_inf, d_inf, a_zero, d_zero;
    sg = a[15] ^ d[15];
    ea = a[14:7];
    ed = d[14:7];
    a_nan = (ea == 255) && (a[6:0] != 0);
    d_nan = (ed == 255) && (d[6:0] != 0);
    a_inf = (ea == 255) && (a[6:0] == 0);
    d_inf = (ed == 255) && (d[6:0] == 0);
    a_zero = (a[14:0] == 0);
    d_zero = (d[14:0] == 0);
    if (a_nan || d_nan || (a_inf && d_inf) || (a_zero && d_zero)) return 32'h7FC00000;
    if (a_inf || d_zero) return {sg, 31'h7F800000};
    if (a_zero || d_inf) return {sg, 31'h0};
    xs = (ea == 0) ? a[6:0] : {1'b1, a[6:0]};
    ex = (ea == 0) ? -133 : ea - 134;
    ss = (ed == 0) ? d[6:0] : {1'b1, d[6:0]};
    es = (ed == 0) ? -133 : ed - 134;
    q = (xs << 40) / ss;
    r = (xs << 40) % ss;
    st = (r != 0);
    p = 0;
    for (int i = 0; i < 64; i++) if (q[i]) p = i;
    base = ex - es - 40;
    e = p + base;
    sh = (e >= -126) ? p - 23 : -149 - base;
    if (sh >= 62) begin
      kept = 0;
    end else begin
      kept = q >> sh;
      g = q[sh-1];
      low = ((q & ((64'd1 << (sh - 1)) - 1)) != 0) || st;
      if (g && (low || kept[0])) kept = kept + 1;
    end
    if (e >= -126) begin
      bits = (64'(e + 127) << 23) + kept - (64'd1 << 23);
      if (bits >= 64'h7F800000) bits = 64'h7F800000;
    end else begin
      bits = kept;
    end
    return {sg, bits[30:0]};
  endfunction

  function automatic int shift_rne(input int v, input int sh);
    int t, r, half;
    if (sh <= 0) return v;
    if (sh >= 10) return 0;
    t = v >> sh;
    r = v & ((1 << sh) - 1);
    half = 1 << (sh - 1);
    return t + (((r > half) || (r == half && t[0])) ? 1 : 0);
  endfunction

  function automatic logic [7:0] fp8_quantize(input logic [15:0] x);
    logic [31:0] w;
    logic [15:0] b;
    logic [14:0] mag, lim;
    logic [7:0]  sgn;
    int          mbits, bias, e, m, unb, te, sig;
    w = fp32_quotient(x, cur_scale);
    if (w[30:0] > 31'h7F800000) return NAN_BYTE;
    w = w + 32'h7FFF + w[16];
    b = w[31:16];
    mag = b[14:0];
    lim = (cur_format == FMT_E5M2) ? LIM_E5M2 : LIM_E4M3;
    if (mag > lim) mag = lim;
    mbits = (cur_format == FMT_E5M2) ? 2 : 3;
    bias = (cur_format == FMT_E5M2) ? 15 : 7;
    sgn = b[15] ? 8'h80 : 8'h00;
    e = mag[14:7];
    m = mag[6:0];
    if (e == 0) return sgn;
    if (e == 255) return NAN_BYTE;
    unb = e - 127;
    te = unb + bias;
    if (te <= 0) return sgn | (8'(shift_rne(128 + m, 8 - unb - bias - mbits)) & 8'h7F);
    sig = shift_rne(128 + m, 7 - mbits);
    if (sig == (1 << (mbits + 1))) begin
      te++;
      sig = sig >> 1;
    end
    sig = sig - (1 << mbits);
    return sgn | (8'((te << mbits) | sig) & 8'h7F);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (no_gaps || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end
  end

  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (fp8_expected.size() == 0) begin
        $display("%0t unexpected transfer: actual %02h", $time, fp8_out);
        errors++;
      end else begin
        if (fp8_out !== fp8_expected[0]) begin
          $display("%0t mismatch in %04h scale %04h fmt %0d: expected %02h actual %02h",
                   $time, fp8_source[0], cur_scale, cur_format, fp8_expected[0], fp8_out);
          errors++;
        end
        void'(fp8_expected.pop_front());
        void'(fp8_source.pop_front());
        checked++;
      end
    end
  end

  task automatic send_element(input logic [15:0] v);
    int gap;
    gap = no_gaps ? 0 : (($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                    : $urandom_range(5, 30));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    bf16_in <= v;
    forever begin
      @(negedge clk);
      if (in_ready) begin
        fp8_expected.push_back(fp8_quantize(v));
        fp8_source.push_back(v);
        sent++;
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
  endtask

  task automatic write_config(input logic [1:0] idx, input logic [15:0] val);
    in_valid <= 1'b0;
    wait (fp8_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SCALE) cur_scale = val;
    else cur_format = val[0];
  endtask

  function automatic logic [15:0] pick_element();
    int e, sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      e = int'(cur_scale[14:7]) + $urandom_range(0, 44) - 30;
      if (e < 1) e = 1;
      if (e > 254) e = 254;
      return {1'($urandom_range(0, 1)), 8'(e), 7'($urandom_range(0, 127))};
    end
    if (sel < 8) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0: return {1'($urandom_range(0, 1)), 15'h0};
      1: return {1'($urandom_range(0, 1)), 15'h7F80};
      2: return {1'($urandom_range(0, 1)), 8'hFF, 7'($urandom_range(1, 127))};
      default: return {1'($urandom_range(0, 1)), 8'h00, 7'($urandom_range(1, 127))};
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] vals[] = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC0, 16'hFFFF,
                            16'h0001, 16'h807F, 16'h3F80, 16'hBF80, 16'h43E0, 16'h43E8,
                            16'hC3F0, 16'h7F7F, 16'h3B00, 16'h3A80, 16'h3A00, 16'h3C10,
                            16'h3C18, 16'h4390, 16'h3F88, 16'h3F98};
    for (int f = 0; f < 2; f++) begin
      write_config(CFG_FORMAT, f[15:0]);
      foreach (vals[i]) send_element(vals[i]);
      if (f == 1) begin
        send_element(16'h3780);
        send_element(16'h3700);
        send_element(16'h4760);
        send_element(16'h4770);
      end
    end
  endtask

  task automatic test_special_scales();
    logic [15:0] scales[] = '{16'h0000, 16'h8000, 16'h7F80, 16'h7FC1, 16'h0001};
    foreach (scales[i]) begin
      write_config(CFG_SCALE, scales[i]);
      send_element(16'h0000);
      send_element(16'h3F80);
      send_element(16'hFF80);
      send_element(16'h0040);
    end
  endtask

  task automatic test_random_phase(input logic [15:0] scale, input logic fmt, input int n);
    write_config(CFG_SCALE, scale);
    write_config(CFG_FORMAT, {15'h0, fmt});
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_element(pick_element());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_element(16'h3F80);
    send_element(16'h43E0);
    test_directed();
    test_special_scales();
    test_random_phase(SCALE_RESET, FMT_E4M3, 150);
    test_random_phase(SCALE_RESET, FMT_E5M2, 150);
    test_random_phase(16'h7F7F, FMT_E4M3, 100);
    test_random_phase(16'h0001, FMT_E5M2, 100);
    test_random_phase(16'hFFFF, FMT_E4M3, 40);
    for (int k = 0; k < 10; k++)
      test_random_phase(16'($urandom_range(0, 65535)), 1'(k), 100);
    in_valid <= 1'b0;
    wait (fp8_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d elements, %0d results checked, both formats, special and random scales",
             sent, checked);
    if (errors == 0 && fp8_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d errors", errors);
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: filelist.f
hdl/bfq_pkg.sv
hdl/bfq_unpack.sv
hdl/bfq_div_stage.sv
hdl/bfq_round.sv
hdl/bfq_encode.sv
hdl/bf16_to_fp8_scaled_quantizer.sv
dv/testbench.sv
